/* src/dcti_pkg.sv */
// Shared types and constants for the DUART counter/timer and interrupt block.
package dcti_pkg;

  // Timer clocking: counter clock divide, and an extra divide for single-shot mode.
  localparam int unsigned CLOCK_RATIO   = 8;
  localparam int unsigned SHOT_PRESCALE = 16;
  localparam int unsigned SHOT_MULT     = CLOCK_RATIO * SHOT_PRESCALE;

  // Timer storage widths and the lengths they saturate to.
  localparam int unsigned TICKS_W  = 23;
  localparam int unsigned PERIOD_W = 19;
  localparam int unsigned COUNT_W  = 16;
  localparam int unsigned SHOT_LEN_W = COUNT_W + $clog2(SHOT_MULT + 1);
  localparam int unsigned PER_LEN_W  = COUNT_W + $clog2(CLOCK_RATIO + 1);
  localparam logic [TICKS_W-1:0]  TICKS_MAX  = '1;
  localparam logic [PERIOD_W-1:0] PERIOD_MAX = '1;

  // Request kinds.
  typedef enum logic [1:0] {
    ACT_TICK  = 2'd0,
    ACT_READ  = 2'd1,
    ACT_WRITE = 2'd2
  } action_t;

  // Register offsets.
  localparam logic [3:0] REG_ACR    = 4'h4;
  localparam logic [3:0] REG_IMR    = 4'h5;
  localparam logic [3:0] REG_CTUR   = 4'h6;
  localparam logic [3:0] REG_CTLR   = 4'h7;
  localparam logic [3:0] REG_IVR    = 4'hC;
  localparam logic [3:0] REG_IPR    = 4'hE;
  localparam logic [3:0] REG_STOP   = 4'hF;

  // Timer modes in ACR bits 6..4.
  localparam logic [2:0] MODE_SHOT     = 3'd3;
  localparam logic [2:0] MODE_PERIODIC = 3'd6;

  // Read data constants and the timer interrupt bit.
  localparam logic [7:0] RD_IPR     = 8'h01;
  localparam logic [7:0] RD_STOP    = 8'h00;
  localparam logic [7:0] RD_UNUSED  = 8'hFF;
  localparam int unsigned TIMER_BIT = 3;

  // One request as it moves through the block.
  typedef struct packed {
    logic [1:0] action;
    logic [3:0] reg_offset;
    logic [7:0] write_byte;
  } item_t;

  // One response.
  typedef struct packed {
    logic [7:0] read_byte;
    logic       irq_line;
    logic [7:0] irq_vector;
  } result_t;

endpackage

/* src/dcti_if.sv */
// Request and response channel interfaces with valid/ready handshake.
interface dcti_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [3:0] reg_offset;
  logic [7:0] write_byte;

  modport source (output valid, action, reg_offset, write_byte, input ready);
  modport sink (input valid, action, reg_offset, write_byte, output ready);
endinterface

interface dcti_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_byte;
  logic       irq_line;
  logic [7:0] irq_vector;

  modport source (output valid, read_byte, irq_line, irq_vector, input ready);
  modport sink (input valid, read_byte, irq_line, irq_vector, output ready);
endinterface

/* src/dcti_core.sv */
// Timer and interrupt state with the single-pass update for one request.
module dcti_core (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  dcti_pkg::item_t item,
  output dcti_pkg::result_t result
);

  logic [dcti_pkg::COUNT_W-1:0]  count_preset, count_preset_next;
  logic [7:0]                    int_mask, int_mask_next;
  logic [7:0]                    vector_value, vector_value_next;
  logic [7:0]                    int_status, int_status_next;
  logic                          irq_level, irq_level_next;
  logic [7:0]                    presented_vector, presented_vector_next;
  logic [dcti_pkg::TICKS_W-1:0]  ticks_left, ticks_left_next;
  logic [dcti_pkg::PERIOD_W-1:0] reload_period, reload_period_next;
  logic                          timer_armed, timer_armed_next;
  logic                          periodic_mode, periodic_mode_next;

  logic [dcti_pkg::SHOT_LEN_W-1:0] shot_len;
  logic [dcti_pkg::PER_LEN_W-1:0]  per_len;
  logic [dcti_pkg::TICKS_W-1:0]    shot_sat;
  logic [dcti_pkg::PERIOD_W-1:0]   per_sat;
  logic [7:0]                      rd;

  // Timer lengths from the count preset, saturated to the storage widths.
  assign shot_len = dcti_pkg::SHOT_LEN_W'(count_preset)
                  * dcti_pkg::SHOT_LEN_W'(dcti_pkg::SHOT_MULT);
  assign per_len  = dcti_pkg::PER_LEN_W'(count_preset)
                  * dcti_pkg::PER_LEN_W'(dcti_pkg::CLOCK_RATIO);
  assign shot_sat = (shot_len > dcti_pkg::SHOT_LEN_W'(dcti_pkg::TICKS_MAX))
                  ? dcti_pkg::TICKS_MAX : dcti_pkg::TICKS_W'(shot_len);
  assign per_sat  = (per_len > dcti_pkg::PER_LEN_W'(dcti_pkg::PERIOD_MAX))
                  ? dcti_pkg::PERIOD_MAX : dcti_pkg::PERIOD_W'(per_len);

  // Next state and read data for the request in hand.
  always_comb begin
    count_preset_next     = count_preset;
    int_mask_next         = int_mask;
    vector_value_next     = vector_value;
    int_status_next       = int_status;
    irq_level_next        = irq_level;
    presented_vector_next = presented_vector;
    ticks_left_next       = ticks_left;
    reload_period_next    = reload_period;
    timer_armed_next      = timer_armed;
    periodic_mode_next    = periodic_mode;
    rd                    = 8'h00;

    case (dcti_pkg::action_t'(item.action))
      dcti_pkg::ACT_TICK: begin
        if (timer_armed) begin
          if (ticks_left <= dcti_pkg::TICKS_W'(1)) begin
            // The timer fires; only an unmasked fire reaches the CPU.
            if (int_mask[dcti_pkg::TIMER_BIT]) begin
              presented_vector_next = vector_value;
              irq_level_next        = 1'b1;
              int_status_next       = int_status | (8'h01 << dcti_pkg::TIMER_BIT);
            end
            if (periodic_mode) begin
              ticks_left_next = dcti_pkg::TICKS_W'(reload_period);
            end else begin
              ticks_left_next  = '0;
              timer_armed_next = 1'b0;
            end
          end else begin
            ticks_left_next = ticks_left - dcti_pkg::TICKS_W'(1);
          end
        end
      end
      dcti_pkg::ACT_READ: begin
        if (item.reg_offset == dcti_pkg::REG_IMR) begin
          rd              = int_status;
          int_status_next = 8'h00;
        end else if (item.reg_offset == dcti_pkg::REG_IPR) begin
          rd = dcti_pkg::RD_IPR;
        end else if (item.reg_offset == dcti_pkg::REG_STOP) begin
          rd             = dcti_pkg::RD_STOP;
          irq_level_next = 1'b0;
        end else begin
          rd = dcti_pkg::RD_UNUSED;
        end
      end
      dcti_pkg::ACT_WRITE: begin
        case (item.reg_offset)
          dcti_pkg::REG_ACR: begin
            if (item.write_byte[6:4] == dcti_pkg::MODE_SHOT) begin
              periodic_mode_next = 1'b0;
              ticks_left_next    = shot_sat;
              reload_period_next = '0;
              timer_armed_next   = 1'b1;
            end else if (item.write_byte[6:4] == dcti_pkg::MODE_PERIODIC) begin
              periodic_mode_next = 1'b1;
              reload_period_next = per_sat;
              ticks_left_next    = dcti_pkg::TICKS_W'(per_sat);
              timer_armed_next   = 1'b1;
            end
          end
          dcti_pkg::REG_IMR:  int_mask_next = item.write_byte;
          dcti_pkg::REG_CTUR: count_preset_next = {item.write_byte, count_preset[7:0]};
          dcti_pkg::REG_CTLR: count_preset_next = {count_preset[15:8], item.write_byte};
          dcti_pkg::REG_IVR:  vector_value_next = item.write_byte;
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  // Response reflects the state after this request.
  assign result.read_byte  = rd;
  assign result.irq_line   = irq_level_next;
  assign result.irq_vector = presented_vector_next;

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      count_preset     <= '0;
      int_mask         <= '0;
      vector_value     <= '0;
      int_status       <= '0;
      irq_level        <= 1'b0;
      presented_vector <= '0;
      ticks_left       <= '0;
      reload_period    <= '0;
      timer_armed      <= 1'b0;
      periodic_mode    <= 1'b0;
    end else if (en) begin
      count_preset     <= count_preset_next;
      int_mask         <= int_mask_next;
      vector_value     <= vector_value_next;
      int_status       <= int_status_next;
      irq_level        <= irq_level_next;
      presented_vector <= presented_vector_next;
      ticks_left       <= ticks_left_next;
      reload_period    <= reload_period_next;
      timer_armed      <= timer_armed_next;
      periodic_mode    <= periodic_mode_next;
    end
  end

  // A periodic count never exceeds its reload value.
  a_periodic_bound: assert property (@(posedge clk) disable iff (rst)
    periodic_mode |-> ticks_left <= dcti_pkg::TICKS_W'(reload_period))
    else $error("periodic count above reload period");

  // A single shot goes idle once it fires.
  a_shot_idle: assert property (@(posedge clk) disable iff (rst)
    en && item.action == dcti_pkg::ACT_TICK && timer_armed && !periodic_mode
    && ticks_left <= dcti_pkg::TICKS_W'(1) |=> !timer_armed)
    else $error("single shot still armed after firing");

  // The interrupt line only rises while the timer interrupt is unmasked.
  a_irq_masked: assert property (@(posedge clk) disable iff (rst)
    $rose(irq_level) |-> int_mask[dcti_pkg::TIMER_BIT])
    else $error("interrupt raised while masked");

  // Reading status clears it.
  a_status_clear: assert property (@(posedge clk) disable iff (rst)
    en && item.action == dcti_pkg::ACT_READ && item.reg_offset == dcti_pkg::REG_IMR
    |=> int_status == 8'h00)
    else $error("status not cleared by read");

endmodule

/* src/duart_counter_timer_irq.sv */
// Top level of the DUART counter/timer and interrupt block.
//
// Requests arrive on req: a CPU clock tick, a register read or a register
// write. Each request gives exactly one response on rsp carrying the read
// data, the interrupt line level and the presented vector after that request.
// A request is taken into an input register, processed by combinational
// logic against the timer state, and the response lands in an output
// register. rsp.valid rises when the request moves on from the input
// register, which it does once the output register is free or draining.
// Throughput is one request per cycle while rsp.ready stays high; the state
// update is done in combinational logic between the two registers, which
// allows this, since each request sees the state left by the one before it.
// When rsp.ready is low the response waits in the output register and the
// input register holds one more request; req.ready then drops until the
// response is taken. Nothing is lost or repeated.
// Synchronous reset clears the timer, mask, status, vector and both
// pipeline valid flags; the timer comes out of reset idle, and no request
// is taken while reset is high.
module duart_counter_timer_irq (
  input  logic         clk,
  input  logic         rst,
  dcti_req_if.sink     req,
  dcti_rsp_if.source   rsp
);

  logic              in_valid;
  dcti_pkg::item_t   in_item;
  logic              out_valid;
  dcti_pkg::result_t out_result;
  dcti_pkg::result_t core_result;
  logic              advance;

  // A held request moves on when the output register is free or draining.
  assign advance   = in_valid && (!out_valid || rsp.ready);
  assign req.ready = !rst && (!in_valid || advance);

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (req.ready) begin
      in_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.ready && req.valid) begin
      in_item <= '{action: req.action, reg_offset: req.reg_offset,
                   write_byte: req.write_byte};
    end
  end

  // State update for the held request.
  dcti_core u_core (
    .clk    (clk),
    .rst    (rst),
    .en     (advance),
    .item   (in_item),
    .result (core_result)
  );

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_result <= core_result;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.read_byte  = out_result.read_byte;
  assign rsp.irq_line   = out_result.irq_line;
  assign rsp.irq_vector = out_result.irq_vector;

endmodule

/* tb/tb_duart_counter_timer_irq.sv */
// Self-checking testbench for the DUART counter/timer and interrupt block.
`timescale 1ns / 100ps

module tb_duart_counter_timer_irq;

  // The spare action code does nothing and reads back zero.
  localparam logic [1:0] ACT_SPARE = 2'd3;

  localparam int unsigned RANDOM_REQUESTS = 1400;
  localparam int unsigned HOLD_AT = 400;
  localparam int unsigned DRAIN_AT = 800;
  localparam int unsigned LONG_HOLD_CYCLES = 160;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned CYCLE_LIMIT = 1000000;

  typedef struct {
    dcti_pkg::item_t   req;
    bit                fixed;
    dcti_pkg::result_t want;
  } dir_row_t;

  logic clk;
  logic rst;

  dcti_req_if req_ch ();
  dcti_rsp_if rsp_ch ();

  duart_counter_timer_irq dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Predicted timer and interrupt state, all starting at the reset values.
  logic [dcti_pkg::COUNT_W-1:0]  cnt_preset  = '0;
  logic [7:0]                    imr         = '0;
  logic [7:0]                    ivr_val     = '0;
  logic [7:0]                    isr         = '0;
  logic                          irq_lvl     = 1'b0;
  logic [7:0]                    irq_vec     = '0;
  logic [dcti_pkg::TICKS_W-1:0]  ticks_to_go = '0;
  logic [dcti_pkg::PERIOD_W-1:0] period_len  = '0;
  logic                          tmr_run     = 1'b0;
  logic                          tmr_repeat  = 1'b0;

  dcti_pkg::result_t outcome_q [$];
  dir_row_t dir_rows [$];
  int unsigned err_count = 0;
  int unsigned cycles = 0;
  bit tx_calm = 1'b0;
  bit want_long_hold = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Apply one request to the predicted state and return the response it gives.
  function automatic dcti_pkg::result_t cpu_access_outcome(input dcti_pkg::item_t it);
    dcti_pkg::result_t r;
    int unsigned span;
    r = '0;
    case (it.action)
      dcti_pkg::ACT_TICK: begin
        if (tmr_run) begin
          if (ticks_to_go <= 1) begin
            if (imr[dcti_pkg::TIMER_BIT]) begin
              irq_vec = ivr_val;
              irq_lvl = 1'b1;
              isr[dcti_pkg::TIMER_BIT] = 1'b1;
            end
            if (tmr_repeat) begin
              ticks_to_go = dcti_pkg::TICKS_W'(period_len);
            end else begin
              ticks_to_go = '0;
              tmr_run = 1'b0;
            end
          end else begin
            ticks_to_go = ticks_to_go - 1'b1;
          end
        end
      end
      dcti_pkg::ACT_READ: begin
        case (it.reg_offset)
          // Offset 5 reads the interrupt status and clears it.
          dcti_pkg::REG_IMR: begin
            r.read_byte = isr;
            isr = '0;
          end
          dcti_pkg::REG_IPR: r.read_byte = dcti_pkg::RD_IPR;
          dcti_pkg::REG_STOP: begin
            r.read_byte = dcti_pkg::RD_STOP;
            irq_lvl = 1'b0;
          end
          default: r.read_byte = dcti_pkg::RD_UNUSED;
        endcase
      end
      dcti_pkg::ACT_WRITE: begin
        case (it.reg_offset)
          dcti_pkg::REG_ACR: begin
            if (it.write_byte[6:4] == dcti_pkg::MODE_SHOT) begin
              span = dcti_pkg::SHOT_MULT * cnt_preset;
              ticks_to_go = (span > dcti_pkg::TICKS_MAX) ? dcti_pkg::TICKS_MAX
                                                         : dcti_pkg::TICKS_W'(span);
              period_len = '0;
              tmr_repeat = 1'b0;
              tmr_run = 1'b1;
            end else if (it.write_byte[6:4] == dcti_pkg::MODE_PERIODIC) begin
              span = dcti_pkg::CLOCK_RATIO * cnt_preset;
              period_len = (span > dcti_pkg::PERIOD_MAX) ? dcti_pkg::PERIOD_MAX
                                                         : dcti_pkg::PERIOD_W'(span);
              ticks_to_go = dcti_pkg::TICKS_W'(period_len);
              tmr_repeat = 1'b1;
              tmr_run = 1'b1;
            end
          end
          dcti_pkg::REG_IMR:  imr = it.write_byte;
          dcti_pkg::REG_CTUR: cnt_preset[15:8] = it.write_byte;
          dcti_pkg::REG_CTLR: cnt_preset[7:0] = it.write_byte;
          dcti_pkg::REG_IVR:  ivr_val = it.write_byte;
          default: ;
        endcase
      end
      default: ;
    endcase
    r.irq_line = irq_lvl;
    r.irq_vector = irq_vec;
    return r;
  endfunction

  // Idle length: mostly none, some short, a few long; none in calm stretches.
  function automatic int unsigned idle_gap(input bit calm);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (calm || pick < 75) return 0;
    if (pick < 96) return $urandom_range(1, 3);
    return $urandom_range(12, 40);
  endfunction

  function automatic void add_row(input logic [1:0] act, input logic [3:0] off,
                                  input logic [7:0] data, input bit fixed,
                                  input logic [7:0] rd, input logic irq,
                                  input logic [7:0] vec);
    dir_row_t row;
    row.req.action = act;
    row.req.reg_offset = off;
    row.req.write_byte = data;
    row.fixed = fixed;
    row.want.read_byte = rd;
    row.want.irq_line = irq;
    row.want.irq_vector = vec;
    dir_rows.push_back(row);
  endfunction

  // Random request, mostly timer ticks, then register writes and status reads.
  function automatic dcti_pkg::item_t random_request();
    dcti_pkg::item_t it;
    int unsigned pick;
    it.action = dcti_pkg::ACT_TICK;
    it.reg_offset = 4'($urandom_range(0, 15));
    it.write_byte = 8'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 4) begin
      it.action = ACT_SPARE;
    end else if (pick < 58) begin
      it.action = dcti_pkg::ACT_TICK;
    end else if (pick < 75) begin
      it.action = dcti_pkg::ACT_READ;
      case ($urandom_range(0, 3))
        0: it.reg_offset = dcti_pkg::REG_IMR;
        1: it.reg_offset = dcti_pkg::REG_STOP;
        2: it.reg_offset = dcti_pkg::REG_IPR;
        default: ;
      endcase
    end else begin
      it.action = dcti_pkg::ACT_WRITE;
      case ($urandom_range(0, 6))
        0, 1: begin
          it.reg_offset = dcti_pkg::REG_ACR;
          if ($urandom_range(0, 4) != 0)
            it.write_byte[6:4] = $urandom_range(0, 1) ? dcti_pkg::MODE_SHOT
                                                      : dcti_pkg::MODE_PERIODIC;
        end
        2: begin
          it.reg_offset = dcti_pkg::REG_IMR;
          if ($urandom_range(0, 3) != 0) it.write_byte[dcti_pkg::TIMER_BIT] = 1'b1;
        end
        // Keep counts small so that timers expire within the run.
        3: begin
          it.reg_offset = dcti_pkg::REG_CTUR;
          if ($urandom_range(0, 9) != 0) it.write_byte = '0;
        end
        4: begin
          it.reg_offset = dcti_pkg::REG_CTLR;
          if ($urandom_range(0, 4) != 0) it.write_byte = 8'($urandom_range(0, 3));
        end
        5: it.reg_offset = dcti_pkg::REG_IVR;
        default: ;
      endcase
    end
    return it;
  endfunction

  // Present one request after an optional gap and hold it until accepted.
  task automatic offer(input dcti_pkg::item_t it);
    int unsigned gap;
    gap = idle_gap(tx_calm);
    if (gap != 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.action <= it.action;
    req_ch.reg_offset <= it.reg_offset;
    req_ch.write_byte <= it.write_byte;
    do @(posedge clk); while (!req_ch.ready);
  endtask

  // Request side: reset, directed rows, then random traffic.
  initial begin : req_side
    dcti_pkg::item_t it;
    dcti_pkg::result_t want;
    int unsigned tick_run;
    tick_run = 0;
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.action <= dcti_pkg::ACT_TICK;
    req_ch.reg_offset <= '0;
    req_ch.write_byte <= '0;

    // After reset: constant reads, idle tick, spare action.
    add_row(dcti_pkg::ACT_READ, dcti_pkg::REG_IPR, 8'h00, 1'b1, dcti_pkg::RD_IPR, 1'b0, 8'h00);
    add_row(dcti_pkg::ACT_READ, dcti_pkg::REG_IMR, 8'h00, 1'b1, 8'h00, 1'b0, 8'h00);
    add_row(dcti_pkg::ACT_READ, 4'h3, 8'h00, 1'b1, dcti_pkg::RD_UNUSED, 1'b0, 8'h00);
    add_row(dcti_pkg::ACT_TICK, 4'h0, 8'h00, 1'b1, 8'h00, 1'b0, 8'h00);
    add_row(ACT_SPARE, dcti_pkg::REG_STOP, 8'hFF, 1'b1, 8'h00, 1'b0, 8'h00);
    // Zero-period periodic timer fires on every tick.
    add_row(dcti_pkg::ACT_WRITE, dcti_pkg::REG_IVR, 8'hFF, 1'b1, 8'h00, 1'b0, 8'h00);
    add_row(dcti_pkg::ACT_WRITE, dcti_pkg::REG_IMR, 8'h08, 1'b1, 8'h00, 1'b0, 8'h00);
    add_row(dcti_pkg::ACT_WRITE, dcti_pkg::REG_CTUR, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00);
    add_row(dcti_pkg::ACT_WRITE, dcti_pkg::REG_CTLR, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00);
    add_row(dcti_pkg::ACT_WRITE, dcti_pkg::REG_ACR, 8'h60, 1'b1, 8'h00, 1'b0, 8'h00);
    add_row(dcti_pkg::ACT_TICK, 4'h0, 8'h00, 1'b1, 8'h00, 1'b1, 8'hFF);
    add_row(dcti_pkg::ACT_READ, dcti_pkg::REG_IMR, 8'h00, 1'b1, 8'h08, 1'b1, 8'hFF);
    add_row(dcti_pkg::ACT_READ, dcti_pkg::REG_IMR, 8'h00, 1'b1, 8'h00, 1'b1, 8'hFF);
    add_row(dcti_pkg::ACT_READ, dcti_pkg::REG_STOP, 8'h00, 1'b1, dcti_pkg::RD_STOP, 1'b0,
            8'hFF);
    add_row(dcti_pkg::ACT_TICK, 4'h0, 8'h00, 1'b1, 8'h00, 1'b1, 8'hFF);
    // A masked firing changes only the timer.
    add_row(dcti_pkg::ACT_WRITE, dcti_pkg::REG_IMR, 8'hF7, 1'b1, 8'h00, 1'b1, 8'hFF);
    add_row(dcti_pkg::ACT_READ, dcti_pkg::REG_STOP, 8'h00, 1'b1, dcti_pkg::RD_STOP, 1'b0,
            8'hFF);
    add_row(dcti_pkg::ACT_TICK, 4'h0, 8'h00, 1'b1, 8'h00, 1'b0, 8'hFF);
    // Largest count in both modes, an ignored mode and an ignored offset.
    add_row(dcti_pkg::ACT_WRITE, dcti_pkg::REG_CTUR, 8'hFF, 1'b0, 8'h00, 1'b0, 8'h00);
    add_row(dcti_pkg::ACT_WRITE, dcti_pkg::REG_CTLR, 8'hFF, 1'b0, 8'h00, 1'b0, 8'h00);
    add_row(dcti_pkg::ACT_WRITE, dcti_pkg::REG_ACR, 8'h30, 1'b0, 8'h00, 1'b0, 8'h00);
    add_row(dcti_pkg::ACT_WRITE, dcti_pkg::REG_ACR, 8'h8F, 1'b0, 8'h00, 1'b0, 8'h00);
    add_row(dcti_pkg::ACT_WRITE, dcti_pkg::REG_ACR, 8'h60, 1'b0, 8'h00, 1'b0, 8'h00);
    add_row(dcti_pkg::ACT_WRITE, 4'h0, 8'hAA, 1'b0, 8'h00, 1'b0, 8'h00);
    add_row(dcti_pkg::ACT_TICK, 4'h0, 8'h00, 1'b0, 8'h00, 1'b0, 8'h00);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed rows: fixed expectations where given, predicted otherwise.
    foreach (dir_rows[i]) begin
      offer(dir_rows[i].req);
      want = cpu_access_outcome(dir_rows[i].req);
      outcome_q.push_back(dir_rows[i].fixed ? dir_rows[i].want : want);
    end

    // Random traffic with occasional long tick runs so one-shots can expire.
    for (int unsigned n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n == HOLD_AT) want_long_hold = 1'b1;
      if (n == DRAIN_AT) begin
        req_ch.valid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge clk);
      end
      if ($urandom_range(0, 79) == 0) tx_calm = ~tx_calm;
      if (tick_run == 0 && $urandom_range(0, 149) == 0)
        tick_run = $urandom_range(129, 260);
      if (tick_run != 0) begin
        it.action = dcti_pkg::ACT_TICK;
        it.reg_offset = 4'($urandom_range(0, 15));
        it.write_byte = 8'($urandom_range(0, 255));
        tick_run--;
      end else begin
        it = random_request();
      end
      offer(it);
      outcome_q.push_back(cpu_access_outcome(it));
    end
    req_ch.valid <= 1'b0;

    while (outcome_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_duart_counter_timer_irq: PASS");
    end else begin
      $display("tb_duart_counter_timer_irq: FAIL");
    end
    $finish;
  end

  // Response side: compare each response with the oldest prediction and stall at random.
  initial begin : rsp_side
    dcti_pkg::result_t want;
    int unsigned stall_left;
    int unsigned hold_left;
    bit rx_calm;
    stall_left = 0;
    hold_left = 0;
    rx_calm = 1'b0;
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (outcome_q.size() == 0) begin
          $error("response with no request outstanding");
          err_count++;
        end else begin
          want = outcome_q.pop_front();
          if (rsp_ch.read_byte !== want.read_byte) begin
            $error("read_byte: expected %02h, got %02h", want.read_byte, rsp_ch.read_byte);
            err_count++;
          end
          if (rsp_ch.irq_line !== want.irq_line) begin
            $error("irq_line: expected %0b, got %0b", want.irq_line, rsp_ch.irq_line);
            err_count++;
          end
          if (rsp_ch.irq_vector !== want.irq_vector) begin
            $error("irq_vector: expected %02h, got %02h", want.irq_vector,
                   rsp_ch.irq_vector);
            err_count++;
          end
        end
      end
      if ($urandom_range(0, 199) == 0) rx_calm = ~rx_calm;
      if (want_long_hold) begin
        want_long_hold = 1'b0;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (rst) begin
        rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        rsp_ch.ready <= 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        rsp_ch.ready <= 1'b0;
      end else begin
        stall_left = idle_gap(rx_calm);
        rsp_ch.ready <= (stall_left == 0);
        if (stall_left != 0) stall_left--;
      end
    end
  end

  // Watchdog on total run length.
  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb_duart_counter_timer_irq: FAIL");
    $finish;
  end

endmodule

/* files.f */
src/dcti_pkg.sv
src/dcti_if.sv
src/dcti_core.sv
src/duart_counter_timer_irq.sv
tb/tb_duart_counter_timer_irq.sv
